### hdl/cse_pkg.sv
package cse_pkg;

    localparam int MAX_DEGREE_DEF = 5;
    localparam int NUM_COEF       = 6;
    localparam int STAGES         = 7;
    localparam int ADDR_W         = 5;
    localparam int APB_DATA_W     = 32;
    localparam int REG_IDX_W      = 3;

    // register indexes, byte address is 4 * index
    localparam logic [REG_IDX_W-1:0] REG_DEGREE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF0  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF1  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF2  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF3  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COEF4  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COEF5  = 3'd6;

    localparam logic signed [23:0] ONE_Q15  = 24'sd32768;
    localparam logic signed [39:0] RND_HALF = 40'sd16384;
    localparam logic signed [23:0] T16_MAX  = 24'sd32767;
    localparam logic signed [23:0] T16_MIN  = -24'sd32768;
    localparam logic signed [24:0] Y_MAX    = 25'sd262143;
    localparam logic signed [24:0] Y_MIN    = -25'sd262144;

    typedef struct packed {
        logic [2:0]        degree;
        logic [5:0][15:0]  coef;
    } cfg_t;

    // divide by 2^15, round half up
    function automatic logic signed [24:0] rnd15(input logic signed [39:0] v);
        logic signed [39:0] w;
        begin
            w = v + RND_HALF;
            return 25'(w >>> 15);
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        begin
            if (v > T16_MAX)
                return 16'sh7fff;
            else if (v < T16_MIN)
                return 16'sh8000;
            else
                return 16'(v);
        end
    endfunction

    function automatic logic signed [18:0] sat19(input logic signed [24:0] v);
        begin
            if (v > Y_MAX)
                return 19'(Y_MAX);
            else if (v < Y_MIN)
                return 19'(Y_MIN);
            else
                return 19'(v);
        end
    endfunction

endpackage

### hdl/cse_regs.sv
module cse_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cse_pkg::ADDR_W-1:0]       paddr,
    input  logic [cse_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cse_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output cse_pkg::cfg_t                    cfg
);
    import cse_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_DEGREE: cfg_reg.degree  <= pwdata[2:0];
                REG_COEF0:  cfg_reg.coef[0] <= pwdata[15:0];
                REG_COEF1:  cfg_reg.coef[1] <= pwdata[15:0];
                REG_COEF2:  cfg_reg.coef[2] <= pwdata[15:0];
                REG_COEF3:  cfg_reg.coef[3] <= pwdata[15:0];
                REG_COEF4:  cfg_reg.coef[4] <= pwdata[15:0];
                REG_COEF5:  cfg_reg.coef[5] <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DEGREE: prdata = {29'b0, cfg_reg.degree};
            REG_COEF0:  prdata = {16'b0, cfg_reg.coef[0]};
            REG_COEF1:  prdata = {16'b0, cfg_reg.coef[1]};
            REG_COEF2:  prdata = {16'b0, cfg_reg.coef[2]};
            REG_COEF3:  prdata = {16'b0, cfg_reg.coef[3]};
            REG_COEF4:  prdata = {16'b0, cfg_reg.coef[4]};
            REG_COEF5:  prdata = {16'b0, cfg_reg.coef[5]};
            default:    prdata = '0;
        endcase
    end

endmodule

### hdl/chebyshev_series_eval_core.sv
// chebyshev series evaluator, y = b0 + sum of bk * Tk(x) for k = 1 .. degree
//
// input stream: s_axis_* carries one sample x (signed q1.15) per beat, tlast
// marks the end of a sweep and is passed through with the sample.
// output stream: m_axis_* carries y (signed q7.12, saturated) per beat.
// config: apb port, degree at 0x00, coef_0 .. coef_5 at 0x04 .. 0x18, the user must write
// it only while the pipe is empty (not enforced by the block); pready is always high.
//
// throughput is one sample per cycle unless the output stalls. the 7
// register stages follow the power chain x^2, x^3 and x^4, x^5, then the
// coefficient products and the final sum.
// each stage holds a valid bit; a stage takes new data when it is empty or
// the stage after it moves, so bubbles collapse and a stalled output only
// backs up as far as the pipe is full. with the output stalled and all
// stages full, s_axis_tready drops; nothing is lost or repeated.
// reset clears degree and all coefficients and empties the pipe.
module chebyshev_series_eval_core #(
    parameter int MAX_DEGREE = cse_pkg::MAX_DEGREE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cse_pkg::ADDR_W-1:0]       paddr,
    input  logic [cse_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cse_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [15:0]                      s_axis_tdata,  // [15:0] x_sample
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // [18:0] y_value, [23:19] zero
    output logic                             m_axis_tlast
);
    import cse_pkg::*;

    localparam logic [2:0] MAX_DEG = 3'(MAX_DEGREE);

    cfg_t              cfg;
    logic [2:0]        deg_eff;
    logic signed [15:0] b0;
    logic signed [15:0] bk_eff [1:5];

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] en;
    logic              last_reg [STAGES];

    // stage payload
    logic signed [15:0] x0_reg, x1_reg, x2_reg, x3_reg;
    logic signed [16:0] p2_1_reg, p2_2_reg, p3_2_reg, p4_2_reg, p3_3_reg, p5_3_reg;
    logic signed [15:0] t1_3_reg, t2_3_reg, t3_3_reg, t4_3_reg, t5_4_reg;
    logic signed [31:0] prod1_4_reg, prod2_4_reg, prod3_4_reg, prod4_4_reg, prod5_5_reg;
    logic signed [35:0] psum_5_reg;
    logic signed [18:0] y_6_reg;

    logic signed [16:0] p2_next, p3_next, p4_next, p5_next;
    logic signed [15:0] t2_next, t3_next, t4_next, t5_next;
    logic signed [31:0] prod1_next, prod2_next, prod3_next, prod4_next, prod5_next;
    logic signed [35:0] psum_next;
    logic signed [18:0] y_next;

    logic signed [31:0] m_xx;
    logic signed [32:0] m_p2x;
    logic signed [33:0] m_p2p2;
    logic signed [32:0] m_p4x;
    logic signed [23:0] p2w, p3w, p4w, xw2, p3w3, p5w3, xw3;
    logic signed [35:0] total;

    cse_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // terms above the active degree get a zero weight
    always_comb
    begin
        deg_eff = (cfg.degree > MAX_DEG) ? MAX_DEG : cfg.degree;
        b0      = $signed(cfg.coef[0]);
        for (int k = 1; k <= 5; k++)
        begin
            bk_eff[k] = (3'(k) <= deg_eff) ? $signed(cfg.coef[k]) : 16'sd0;
        end
    end

    // stage enables, a stage moves when empty or when its successor moves
    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || m_axis_tready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
                vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < STAGES; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // datapath
    always_comb
    begin
        m_xx    = x0_reg * x0_reg;
        p2_next = 17'(rnd15(40'(m_xx)));

        m_p2x   = p2_1_reg * x1_reg;
        m_p2p2  = p2_1_reg * p2_1_reg;
        p3_next = 17'(rnd15(40'(m_p2x)));
        p4_next = 17'(rnd15(40'(m_p2p2)));

        m_p4x   = p4_2_reg * x2_reg;
        p5_next = 17'(rnd15(40'(m_p4x)));
        p2w     = 24'(p2_2_reg);
        p3w     = 24'(p3_2_reg);
        p4w     = 24'(p4_2_reg);
        xw2     = 24'(x2_reg);
        t2_next = sat16((p2w <<< 1) - ONE_Q15);
        t3_next = sat16((p3w <<< 2) - xw2 * 24'sd3);
        t4_next = sat16((p4w <<< 3) - (p2w <<< 3) + ONE_Q15);

        p3w3    = 24'(p3_3_reg);
        p5w3    = 24'(p5_3_reg);
        xw3     = 24'(x3_reg);
        t5_next = sat16((p5w3 <<< 4) - p3w3 * 24'sd20 + xw3 * 24'sd5);
        prod1_next = bk_eff[1] * t1_3_reg;
        prod2_next = bk_eff[2] * t2_3_reg;
        prod3_next = bk_eff[3] * t3_3_reg;
        prod4_next = bk_eff[4] * t4_3_reg;

        psum_next  = (36'(b0) <<< 15) + 36'(prod1_4_reg) + 36'(prod2_4_reg)
                   + 36'(prod3_4_reg) + 36'(prod4_4_reg);
        prod5_next = bk_eff[5] * t5_4_reg;

        total  = psum_5_reg + 36'(prod5_5_reg);
        y_next = sat19(rnd15(40'(total)));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x0_reg      <= $signed(s_axis_tdata);
            last_reg[0] <= s_axis_tlast;
        end
        if (en[1])
        begin
            x1_reg      <= x0_reg;
            p2_1_reg    <= p2_next;
            last_reg[1] <= last_reg[0];
        end
        if (en[2])
        begin
            x2_reg      <= x1_reg;
            p2_2_reg    <= p2_1_reg;
            p3_2_reg    <= p3_next;
            p4_2_reg    <= p4_next;
            last_reg[2] <= last_reg[1];
        end
        if (en[3])
        begin
            x3_reg      <= x2_reg;
            p3_3_reg    <= p3_2_reg;
            p5_3_reg    <= p5_next;
            t1_3_reg    <= x2_reg;
            t2_3_reg    <= t2_next;
            t3_3_reg    <= t3_next;
            t4_3_reg    <= t4_next;
            last_reg[3] <= last_reg[2];
        end
        if (en[4])
        begin
            prod1_4_reg <= prod1_next;
            prod2_4_reg <= prod2_next;
            prod3_4_reg <= prod3_next;
            prod4_4_reg <= prod4_next;
            t5_4_reg    <= t5_next;
            last_reg[4] <= last_reg[3];
        end
        if (en[5])
        begin
            psum_5_reg  <= psum_next;
            prod5_5_reg <= prod5_next;
            last_reg[5] <= last_reg[4];
        end
        if (en[6])
        begin
            y_6_reg     <= y_next;
            last_reg[6] <= last_reg[5];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[STAGES-1];
    assign m_axis_tdata  = {5'b0, y_6_reg};
    assign m_axis_tlast  = last_reg[STAGES-1];

endmodule

### hdl/cse_checker.sv
module cse_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [cse_pkg::ADDR_W-1:0]       paddr,
    input logic [cse_pkg::APB_DATA_W-1:0]   pwdata,
    input logic [cse_pkg::APB_DATA_W-1:0]   prdata,
    input logic                             pready,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [15:0]                      s_axis_tdata,  // [15:0] x_sample
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [23:0]                      m_axis_tdata,  // [18:0] y_value
    input logic                             m_axis_tlast
);
    import cse_pkg::*;

    // a stalled output beat keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // an empty or draining output stage never blocks the input
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input blocked while output side can move");

    // padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:19] == 5'b0)
        else $error("nonzero padding in output beat");

    // degree written then read back
    a_deg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_DEGREE)
            ##1 (psel && !pwrite && paddr[ADDR_W-1:2] == REG_DEGREE)
            |-> prdata == {29'b0, $past(pwdata[2:0])})
        else $error("degree readback mismatch");

endmodule

bind chebyshev_series_eval_core cse_checker u_cse_checker (.*);
